// File: rtl/blr_pkg.sv
package blr_pkg;

	localparam int unsigned REG_BITS     = 12;
	localparam int unsigned COLOR_BITS   = 24;
	localparam int unsigned CFG_IDX_BITS = 2;

	localparam logic [REG_BITS-1:0] IMAGE_SIZE_RESET = 12'd1024;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		SLOPE_X_UP   = 2'd0,
		SLOPE_X_DOWN = 2'd1,
		SLOPE_Y_UP   = 2'd2,
		SLOPE_Y_DOWN = 2'd3
	} slope_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1
	} cfg_idx_t;

endpackage

// File: rtl/bresenham_line_rasterizer.sv
// bresenham line rasterizer
// input channel: in_valid / in_stall with operation and endpoint/color fields.
//   a start transaction loads a line and returns its first pixel; each step
//   transaction returns the next pixel along the major axis. equal endpoints,
//   and steps with no line in progress, return nothing.
// output channel: out_valid / out_stall, one pixel per transaction, with an
//   in_bounds flag against the configured image size and last_pixel on the end.
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   image_width (0) or image_height (1); write only while the block is idle.
// output: a pixel is registered and presented at out_valid in the cycle after its
//   input transaction. throughput: one transaction per cycle while in_stall is low, set by
//   the single add and compare on the decision variable between the line state
//   and the output register.
// stall: while a pixel waits in the output register under out_stall, in_stall
//   is raised; otherwise a new input is taken in the same cycle the pending
//   pixel leaves.
// reset: no line in progress, output empty, image size 1024 x 1024.
module bresenham_line_rasterizer #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   operation,
	input  logic signed [COORD_BITS-1:0]           x_start,
	input  logic signed [COORD_BITS-1:0]           y_start,
	input  logic signed [COORD_BITS-1:0]           x_end,
	input  logic signed [COORD_BITS-1:0]           y_end,
	input  logic [blr_pkg::COLOR_BITS-1:0]         line_color,

	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [COORD_BITS-1:0]           pixel_x,
	output logic signed [COORD_BITS-1:0]           pixel_y,
	output logic [blr_pkg::COLOR_BITS-1:0]         pixel_color,
	output logic                                   in_bounds,
	output logic                                   last_pixel,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [blr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [blr_pkg::REG_BITS-1:0]           cfg_data
);

	localparam int unsigned CB   = COORD_BITS;
	localparam int unsigned DB   = CB + 1;
	localparam int unsigned DW   = CB + 4;
	localparam int unsigned CMPW = (CB > blr_pkg::REG_BITS) ? CB : blr_pkg::REG_BITS;

	logic                                 in_accept;
	logic [blr_pkg::REG_BITS-1:0]         image_width_q;
	logic [blr_pkg::REG_BITS-1:0]         image_height_q;

	logic                                 active_q;
	blr_pkg::slope_t                      slope_q;
	logic signed [CB-1:0]                 cur_x_q;
	logic signed [CB-1:0]                 cur_y_q;
	logic signed [CB-1:0]                 major_end_q;
	logic signed [DW-1:0]                 decision_q;
	logic signed [DW-1:0]                 inc_straight_q;
	logic signed [DW-1:0]                 inc_diagonal_q;
	logic [blr_pkg::COLOR_BITS-1:0]       held_color_q;

	logic                                 out_valid_q;
	logic signed [CB-1:0]                 pixel_x_q;
	logic signed [CB-1:0]                 pixel_y_q;
	logic [blr_pkg::COLOR_BITS-1:0]       pixel_color_q;
	logic                                 in_bounds_q;
	logic                                 last_pixel_q;

	// start setup
	logic signed [DB-1:0]                 dx, dy, adx, ady, sdx, sdy, a_len, b_len;
	logic                                 xmajor, swap, empty_line;
	logic signed [CB-1:0]                 sx1, sy1, sx2, sy2;
	logic signed [DW-1:0]                 a_w, b_w;
	blr_pkg::slope_t                      start_slope;

	// step
	logic                                 step_xmajor, step_up, dec_pos;
	logic signed [CB-1:0]                 minor_move;
	logic signed [CB-1:0]                 step_x, step_y;
	logic signed [DW-1:0]                 step_decision;
	logic                                 step_last;

	// next state and result
	logic                                 nxt_active;
	blr_pkg::slope_t                      nxt_slope;
	logic signed [CB-1:0]                 nxt_x, nxt_y, nxt_major_end;
	logic signed [DW-1:0]                 nxt_decision, nxt_inc_straight, nxt_inc_diagonal;
	logic [blr_pkg::COLOR_BITS-1:0]       nxt_color;
	logic                                 res_valid, res_last, res_in_bounds;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = out_valid_q && out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		dx         = DB'(x_end) - DB'(x_start);
		dy         = DB'(y_end) - DB'(y_start);
		adx        = dx[DB-1] ? -dx : dx;
		ady        = dy[DB-1] ? -dy : dy;
		xmajor     = ady < adx;
		empty_line = (dx == '0) && (dy == '0);
		swap       = xmajor ? (x_start > x_end) : (y_start > y_end);
		sx1        = swap ? x_end   : x_start;
		sy1        = swap ? y_end   : y_start;
		sx2        = swap ? x_start : x_end;
		sy2        = swap ? y_start : y_end;
		sdx        = swap ? -dx : dx;
		sdy        = swap ? -dy : dy;
		a_len      = xmajor ? adx : ady;
		b_len      = xmajor ? ady : adx;
		a_w        = {{(DW-DB){1'b0}}, a_len};
		b_w        = {{(DW-DB){1'b0}}, b_len};
		if (xmajor) begin
			start_slope = (sdy > 0) ? blr_pkg::SLOPE_X_UP : blr_pkg::SLOPE_X_DOWN;
		end else begin
			start_slope = (sdx >= 0) ? blr_pkg::SLOPE_Y_UP : blr_pkg::SLOPE_Y_DOWN;
		end
	end

	always_comb begin
		step_xmajor = (slope_q == blr_pkg::SLOPE_X_UP) || (slope_q == blr_pkg::SLOPE_X_DOWN);
		step_up     = (slope_q == blr_pkg::SLOPE_X_UP) || (slope_q == blr_pkg::SLOPE_Y_UP);
		dec_pos     = decision_q > 0;
		minor_move  = !dec_pos ? CB'(0) : (step_up ? CB'(1) : -CB'(1));
		step_decision = decision_q + (dec_pos ? inc_diagonal_q : inc_straight_q);
		if (step_xmajor) begin
			step_x    = cur_x_q + CB'(1);
			step_y    = cur_y_q + minor_move;
			step_last = step_x >= major_end_q;
		end else begin
			step_x    = cur_x_q + minor_move;
			step_y    = cur_y_q + CB'(1);
			step_last = step_y >= major_end_q;
		end
	end

	always_comb begin
		nxt_active       = active_q;
		nxt_slope        = slope_q;
		nxt_x            = cur_x_q;
		nxt_y            = cur_y_q;
		nxt_major_end    = major_end_q;
		nxt_decision     = decision_q;
		nxt_inc_straight = inc_straight_q;
		nxt_inc_diagonal = inc_diagonal_q;
		nxt_color        = held_color_q;
		res_valid        = 1'b0;
		res_last         = 1'b0;
		unique case (blr_pkg::op_t'(operation))
			blr_pkg::OP_START: begin
				nxt_color = line_color;
				if (empty_line) begin
					nxt_active = 1'b0;
				end else begin
					nxt_active       = 1'b1;
					nxt_slope        = start_slope;
					nxt_x            = sx1;
					nxt_y            = sy1;
					nxt_major_end    = xmajor ? sx2 : sy2;
					nxt_inc_straight = b_w + b_w;
					nxt_inc_diagonal = (b_w + b_w) - (a_w + a_w);
					nxt_decision     = (b_w + b_w) - a_w;
					res_valid        = 1'b1;
				end
			end
			blr_pkg::OP_STEP: begin
				if (active_q) begin
					nxt_x        = step_x;
					nxt_y        = step_y;
					nxt_decision = step_decision;
					nxt_active   = !step_last;
					res_valid    = 1'b1;
					res_last     = step_last;
				end
			end
			default: begin
				nxt_active = active_q;
			end
		endcase
		res_in_bounds = !nxt_x[CB-1] && !nxt_y[CB-1]
			&& (CMPW'($unsigned(nxt_x)) < CMPW'(image_width_q))
			&& (CMPW'($unsigned(nxt_y)) < CMPW'(image_height_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= blr_pkg::IMAGE_SIZE_RESET;
			image_height_q <= blr_pkg::IMAGE_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				blr_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				blr_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: begin
					image_width_q <= image_width_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			slope_q        <= blr_pkg::SLOPE_X_UP;
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			major_end_q    <= '0;
			decision_q     <= '0;
			inc_straight_q <= '0;
			inc_diagonal_q <= '0;
			held_color_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_accept) begin
				active_q       <= nxt_active;
				slope_q        <= nxt_slope;
				cur_x_q        <= nxt_x;
				cur_y_q        <= nxt_y;
				major_end_q    <= nxt_major_end;
				decision_q     <= nxt_decision;
				inc_straight_q <= nxt_inc_straight;
				inc_diagonal_q <= nxt_inc_diagonal;
				held_color_q   <= nxt_color;
				out_valid_q    <= res_valid;
			end else if (!out_stall) begin
				out_valid_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && res_valid) begin
			pixel_x_q     <= nxt_x;
			pixel_y_q     <= nxt_y;
			pixel_color_q <= nxt_color;
			in_bounds_q   <= res_in_bounds;
			last_pixel_q  <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign in_bounds   = in_bounds_q;
	assign last_pixel  = last_pixel_q;

	// step with no line in progress produces no pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (operation == blr_pkg::OP_STEP) && !active_q |=> !out_valid_q)
		else $error("pixel produced by step with no active line");

	// the end pixel ends the line
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && res_valid && res_last |=> !active_q)
		else $error("line still active after last pixel");

	// degenerate start draws nothing and leaves no line
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (operation == blr_pkg::OP_START) && empty_line
		|=> !out_valid_q && !active_q)
		else $error("equal endpoints produced a pixel or an active line");

	// first pixel of a line is never the last
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (operation == blr_pkg::OP_START) && !empty_line
		|=> out_valid_q && !last_pixel_q && active_q)
		else $error("line start did not present a first pixel");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int CW = 12;
	localparam int COLW = blr_pkg::COLOR_BITS;
	localparam int NUM_PHASES = 5;
	localparam int WIDTHS[NUM_PHASES]  = '{2048, 1, 0, 4095, 300};
	localparam int HEIGHTS[NUM_PHASES] = '{2048, 1, 4095, 0, 37};

	typedef struct {
		blr_pkg::op_t                   op;
		logic signed [CW-1:0]           xs, ys, xe, ye;
		logic [blr_pkg::COLOR_BITS-1:0] color;
	} line_cmd_t;

	typedef struct {
		logic signed [CW-1:0]           x, y;
		logic [blr_pkg::COLOR_BITS-1:0] color;
		logic                           inb;
		logic                           is_last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             operation = blr_pkg::OP_START;
	logic signed [CW-1:0]             x_start = '0, y_start = '0, x_end = '0, y_end = '0;
	logic [blr_pkg::COLOR_BITS-1:0]   line_color = '0;

	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic signed [CW-1:0]             pixel_x, pixel_y;
	logic [blr_pkg::COLOR_BITS-1:0]   pixel_color;
	logic                             in_bounds, last_pixel;

	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [blr_pkg::CFG_IDX_BITS-1:0] cfg_index = blr_pkg::CFG_IMAGE_WIDTH;
	logic [blr_pkg::REG_BITS-1:0]     cfg_data = '0;

	bresenham_line_rasterizer #(.COORD_BITS(CW)) dut (.*);

	always #6 clk = ~clk;

	// rasterizer state as the testbench sees it
	logic [blr_pkg::REG_BITS-1:0]   img_w = blr_pkg::IMAGE_SIZE_RESET;
	logic [blr_pkg::REG_BITS-1:0]   img_h = blr_pkg::IMAGE_SIZE_RESET;
	bit                             line_on = 1'b0;
	blr_pkg::slope_t                slope = blr_pkg::SLOPE_X_UP;
	int                             px, py, major_stop, dec, inc_s, inc_d;
	logic [blr_pkg::COLOR_BITS-1:0] line_col = '0;

	line_cmd_t cmd_queue[$];
	pixel_t    pixels_due[$];
	line_cmd_t drv_cmd;
	pixel_t    drv_pix, mon_pix;
	bit        drv_has_pix;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cmds_sent = 0;
	int cmds_taken = 0;
	int mismatches = 0;
	int pixels_seen = 0;
	int ends_seen = 0;
	int inside_seen = 0;
	int outside_seen = 0;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < 100)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic pixel_t make_pixel(bit is_last);
		pixel_t p;
		p.x = px[CW-1:0];
		p.y = py[CW-1:0];
		p.color = line_col;
		p.inb = px >= 0 && py >= 0 && px < int'(img_w) && py < int'(img_h);
		p.is_last = is_last;
		return p;
	endfunction

	task automatic rasterize(input line_cmd_t c, output bit has_pix, output pixel_t p);
		int x1, y1, x2, y2, dx, dy, adx, ady, a, b, t, dir;
		bit xmajor, is_last;
		has_pix = 1'b0;
		if (c.op == blr_pkg::OP_START) begin
			x1 = c.xs;
			y1 = c.ys;
			x2 = c.xe;
			y2 = c.ye;
			dx = x2 - x1;
			dy = y2 - y1;
			adx = dx < 0 ? -dx : dx;
			ady = dy < 0 ? -dy : dy;
			xmajor = ady < adx;
			line_col = c.color;
			if (adx == 0 && ady == 0) begin
				line_on = 1'b0;
				return;
			end
			if ((xmajor && x1 > x2) || (!xmajor && y1 > y2)) begin
				t = x1; x1 = x2; x2 = t;
				t = y1; y1 = y2; y2 = t;
				dx = -dx;
				dy = -dy;
			end
			if (xmajor) begin
				a = adx;
				b = ady;
				slope = dy > 0 ? blr_pkg::SLOPE_X_UP : blr_pkg::SLOPE_X_DOWN;
				major_stop = x2;
			end else begin
				a = ady;
				b = adx;
				slope = dx >= 0 ? blr_pkg::SLOPE_Y_UP : blr_pkg::SLOPE_Y_DOWN;
				major_stop = y2;
			end
			px = x1;
			py = y1;
			inc_s = 2 * b;
			inc_d = 2 * b - 2 * a;
			dec = 2 * b - a;
			line_on = 1'b1;
			p = make_pixel(1'b0);
			has_pix = 1'b1;
		end else if (line_on) begin
			xmajor = slope == blr_pkg::SLOPE_X_UP || slope == blr_pkg::SLOPE_X_DOWN;
			dir = (slope == blr_pkg::SLOPE_X_UP || slope == blr_pkg::SLOPE_Y_UP) ? 1 : -1;
			if (dec > 0) begin
				dec += inc_d;
				if (xmajor) py += dir;
				else px += dir;
			end else begin
				dec += inc_s;
			end
			if (xmajor) begin
				px += 1;
				is_last = px >= major_stop;
			end else begin
				py += 1;
				is_last = py >= major_stop;
			end
			if (is_last) line_on = 1'b0;
			p = make_pixel(is_last);
			has_pix = 1'b1;
		end
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				rasterize(drv_cmd, drv_has_pix, drv_pix);
				if (drv_has_pix) pixels_due = {pixels_due, drv_pix};
				cmds_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_cmd = cmd_queue.pop_front();
					operation  <= drv_cmd.op;
					x_start    <= drv_cmd.xs;
					y_start    <= drv_cmd.ys;
					x_end      <= drv_cmd.xe;
					y_end      <= drv_cmd.ye;
					line_color <= drv_cmd.color;
					in_valid   <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pixels_due.size() == 0) begin
					report_mismatch("pixel with none pending", 32'({pixel_x, pixel_y}), '0);
				end else begin
					mon_pix = pixels_due.pop_front();
					if (pixel_x !== mon_pix.x)
						report_mismatch("pixel_x", 32'(pixel_x), 32'(mon_pix.x));
					if (pixel_y !== mon_pix.y)
						report_mismatch("pixel_y", 32'(pixel_y), 32'(mon_pix.y));
					if (pixel_color !== mon_pix.color)
						report_mismatch("pixel_color", 32'(pixel_color),
							32'(mon_pix.color));
					if (in_bounds !== mon_pix.inb)
						report_mismatch("in_bounds", 32'(in_bounds), 32'(mon_pix.inb));
					if (last_pixel !== mon_pix.is_last)
						report_mismatch("last_pixel", 32'(last_pixel),
							32'(mon_pix.is_last));
					pixels_seen++;
					if (mon_pix.is_last) ends_seen++;
					if (mon_pix.inb) inside_seen++;
					else outside_seen++;
				end
			end
			out_stall <= $urandom_range(99) < recv_idle_pct;
		end
	end

	task automatic add_cmd(line_cmd_t c);
		cmd_queue = {cmd_queue, c};
		cmds_sent++;
	endtask

	function automatic line_cmd_t start_cmd(int xs, int ys, int xe, int ye,
			logic [blr_pkg::COLOR_BITS-1:0] color);
		line_cmd_t c;
		c.op = blr_pkg::OP_START;
		c.xs = xs[CW-1:0];
		c.ys = ys[CW-1:0];
		c.xe = xe[CW-1:0];
		c.ye = ye[CW-1:0];
		c.color = color;
		return c;
	endfunction

	// step payload is ignored by the block, so fill it with noise
	function automatic line_cmd_t step_cmd();
		line_cmd_t c;
		c.op = blr_pkg::OP_STEP;
		c.xs = CW'($urandom);
		c.ys = CW'($urandom);
		c.xe = CW'($urandom);
		c.ye = CW'($urandom);
		c.color = COLW'($urandom);
		return c;
	endfunction

	// half the picks near the image edges so in_bounds flips
	function automatic int pick_coord(int lim);
		int v;
		case ($urandom_range(3))
			0: v = $urandom_range(4095) - 2048;
			1: v = $urandom_range(40) - 20;
			2: v = lim + $urandom_range(40) - 20;
			default: v = $urandom_range(lim);
		endcase
		if (v > 2047) v = 2047;
		return v;
	endfunction

	task automatic queue_random(int target);
		int n, r, len, x1, y1, x2, y2, dx, dy, steps;
		line_cmd_t c;
		n = 0;
		while (n < target) begin
			r = $urandom_range(99);
			if (r < 6) begin
				c = step_cmd();
				c.op = blr_pkg::op_t'($urandom_range(1));
				add_cmd(c);
				n++;
			end else if (r < 10) begin
				x1 = pick_coord(int'(img_w));
				y1 = pick_coord(int'(img_h));
				add_cmd(start_cmd(x1, y1, x1, y1, COLW'($urandom)));
				n++;
			end else begin
				r = $urandom_range(99);
				len = r < 80 ? $urandom_range(12, 1) :
					r < 97 ? $urandom_range(60, 13) : $urandom_range(300, 61);
				if (len > target - n) len = target - n;
				x1 = pick_coord(int'(img_w));
				y1 = pick_coord(int'(img_h));
				if ($urandom_range(1)) begin
					dx = len;
					dy = $urandom_range(len - 1);
				end else begin
					dy = len;
					dx = $urandom_range(len);
				end
				if ($urandom_range(1)) dx = -dx;
				if ($urandom_range(1)) dy = -dy;
				x2 = x1 + dx;
				if (x2 > 2047 || x2 < -2048) x2 = x1 - dx;
				y2 = y1 + dy;
				if (y2 > 2047 || y2 < -2048) y2 = y1 - dy;
				add_cmd(start_cmd(x1, y1, x2, y2, COLW'($urandom)));
				r = $urandom_range(99);
				steps = r < 75 ? len : r < 88 ? len + $urandom_range(2, 1) : $urandom_range(len - 1);
				repeat (steps) add_cmd(step_cmd());
				n += 1 + steps;
			end
		end
	endtask

	task automatic write_reg(blr_pkg::cfg_idx_t idx, logic [blr_pkg::REG_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == blr_pkg::CFG_IMAGE_WIDTH) img_w = val;
		else img_h = val;
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		while (cmds_taken != cmds_sent) @(posedge clk);
		while (pixels_due.size() > 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (pixels_due.size() > 0) begin
			report_mismatch("pixels never produced", pixels_due.size(), '0);
			pixels_due.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 38;
		recv_idle_pct = 57;

		add_cmd(step_cmd());
		add_cmd(start_cmd(100, 200, 100, 200, 24'h000000));
		add_cmd(start_cmd(0, 0, 3, 0, 24'hffffff));
		repeat (4) add_cmd(step_cmd());
		add_cmd(start_cmd(5, 5, 2, 8, 24'h123456));
		repeat (3) add_cmd(step_cmd());
		add_cmd(start_cmd(-2048, -2048, 2047, 2047, 24'h800001));
		repeat (2) add_cmd(step_cmd());
		add_cmd(start_cmd(2047, -2048, -2048, 2047, 24'h7ffffe));
		add_cmd(step_cmd());
		add_cmd(start_cmd(2047, 5, -2048, 3, 24'h00ff00));
		repeat (2) add_cmd(step_cmd());
		add_cmd(start_cmd(10, -1, 10, -3, 24'h0000ff));
		repeat (2) add_cmd(step_cmd());
		add_cmd(start_cmd(1022, 1023, 1025, 1024, 24'hff0000));
		repeat (3) add_cmd(step_cmd());
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 57;
				recv_idle_pct = 38;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(blr_pkg::CFG_IMAGE_WIDTH, WIDTHS[ph][blr_pkg::REG_BITS-1:0]);
			write_reg(blr_pkg::CFG_IMAGE_HEIGHT, HEIGHTS[ph][blr_pkg::REG_BITS-1:0]);
			queue_random(125);
			drain();
		end

		$display("%0d commands, %0d pixels checked: %0d line ends, %0d inside, %0d outside",
			cmds_sent, pixels_seen, ends_seen, inside_seen, outside_seen);
		$display("image sizes 0 to 4095 per axis, stalls on either side and none, %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout at %0t", $realtime);
		$display("== FAIL ==");
		$finish;
	end

endmodule
